/* rtl/core/feedback_echo_with_bypass_unit_macros.svh */
// assertion macros used by the echo unit top level
`ifndef FEEDBACK_ECHO_WITH_BYPASS_UNIT_MACROS_SVH
`define FEEDBACK_ECHO_WITH_BYPASS_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FEB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("feb: same-cycle check failed");

// next-cycle implication, checked outside reset
`define FEB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("feb: next-cycle check failed");

`endif

/* rtl/core/feb_pkg.sv */
// shared constants and types of the feedback echo unit
`default_nettype none

package feb_pkg;

    // delay ring geometry
    localparam int DELAY_DEPTH = 128;
    localparam int ADDR_W      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int CFG_W    = 8;
    localparam int WORD_W   = 18;
    localparam int FRAC_W   = 8;
    localparam int LEN_W    = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int PROD_W   = WORD_W + CFG_W + 1;
    localparam int SUM_W    = PROD_W - FRAC_W + 1;

    // reset values and levels
    localparam logic [CFG_W-1:0]    GAIN_RESET  = 8'd128;
    localparam logic [CFG_W-1:0]    DELAY_RESET = 8'd100;
    localparam logic [SAMPLE_W-1:0] ZERO_LEVEL  = 8'd127;

    // stored word limits
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FEEDBACK_GAIN = 1'b0,
        CFG_DELAY_LENGTH  = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

/* rtl/core/feb_in_if.sv */
// input word channel: audio sample and button level
`default_nettype none

interface feb_in_if import feb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                button;

    modport source (output valid, output sample, output button, input ready);
    modport sink   (input valid, input sample, input button, output ready);
endinterface

`default_nettype wire

/* rtl/core/feb_out_if.sv */
// output word channel: dac byte and effect led
`default_nettype none

interface feb_out_if import feb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] dac_value;
    logic                led;

    modport source (output valid, output dac_value, output led, input ready);
    modport sink   (input valid, input dac_value, input led, output ready);
endinterface

`default_nettype wire

/* rtl/core/feb_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module feb_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/feedback_echo_with_bypass_unit.sv */
// top level of the feedback comb echo with bypass
//
// usage:
//   i_in carries one word per audio sample: an unsigned 8-bit sample (127 is
//   silence) and the current button level. o_out returns one word per input
//   word: the dac byte and the led flag that was in force for that sample.
//   i_cfg_we / i_cfg_index / i_cfg_data write feedback_gain (index 0) and
//   delay_length (index 1); write them only while no word is in flight.
//   throughput: one word per cycle while the receiver takes words; the ring
//   read is issued on accept, the multiply-add and the write-back happen in
//   the compute stage, and the last write is forwarded to cover a delay of
//   one sample. a stalled receiver holds the output register; the pipeline
//   keeps taking words until both the compute stage and the output register
//   are full.
//   reset (synchronous, active low) empties the pipeline, turns the effect
//   off, zeroes the write pointer and marks every ring entry as zero;
//   there is no clearing pass, words are taken in the first cycle after it.
`default_nettype none
`include "feedback_echo_with_bypass_unit_macros.svh"

module feedback_echo_with_bypass_unit import feb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    feb_in_if.sink                i_in,
    feb_out_if.source             o_out
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                fx;
        logic [ADDR_W-1:0]   waddr;
    } t_s1;

    // configuration and control state
    logic [CFG_W-1:0]       r_gain;
    logic [CFG_W-1:0]       r_delay;
    logic [ADDR_W-1:0]      r_wp;
    logic                   r_effect_on;
    logic                   r_button_before;
    logic [DELAY_DEPTH-1:0] r_mvld;

    // pipeline
    logic                   r_s1_vld;
    t_s1                    r_s1;
    logic [ADDR_W-1:0]      r_s1_raddr;
    logic                   r_s1_mvld;
    logic                   r_fwd_vld;
    logic [ADDR_W-1:0]      r_fwd_addr;
    logic [WORD_W-1:0]      r_fwd_data;
    logic                   r_out_vld;
    logic [SAMPLE_W-1:0]    r_out_dac;
    logic                   r_out_led;

    logic                   acc;
    logic                   s1_go;
    logic                   mem_we;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       wp_ext;
    logic [LEN_W-1:0]       rd_ext;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      n_wp;
    logic [WORD_W-1:0]      ram_rdata;
    logic                   fwd_hit;
    logic signed [WORD_W-1:0] d;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [PROD_W-FRAC_W-1:0] scaled;
    logic signed [SAMPLE_W+1:0] centered;
    logic signed [SUM_W-1:0]  sum;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W:0]   y_out;
    logic [SAMPLE_W-1:0]    echo_byte;
    logic [SAMPLE_W-1:0]    n_dac;

    localparam logic signed [WORD_W:0] DAC_MAX =
        {{(WORD_W+1-SAMPLE_W){1'b0}}, {SAMPLE_W{1'b1}}};

    // handshake
    assign acc         = i_in.valid && i_in.ready;
    assign s1_go       = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_s1_vld || s1_go;
    assign o_out.valid = r_out_vld;
    assign o_out.dac_value = r_out_dac;
    assign o_out.led   = r_out_led;

    // read address: clamped delay behind the write pointer
    always_comb begin
        len = LEN_W'(r_delay);
        if (len == '0) begin
            len = LEN_W'(1);
        end else if (len > LEN_W'(DELAY_DEPTH)) begin
            len = LEN_W'(DELAY_DEPTH);
        end
        wp_ext = LEN_W'(r_wp);
        if (wp_ext >= len) begin
            rd_ext = wp_ext - len;
        end else begin
            rd_ext = wp_ext + LEN_W'(DELAY_DEPTH) - len;
        end
        rd_addr = rd_ext[ADDR_W-1:0];
        n_wp = (r_wp == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : r_wp + ADDR_W'(1);
    end

    // delay ring
    feb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DELAY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s1.waddr),
        .i_wdata (y),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // delayed value: last write forwarded, unwritten entries read as zero
    assign fwd_hit = r_fwd_vld && (r_fwd_addr == r_s1_raddr);
    always_comb begin
        if (fwd_hit) begin
            d = r_fwd_data;
        end else if (r_s1_mvld) begin
            d = ram_rdata;
        end else begin
            d = '0;
        end
    end

    // feedback scale, truncating toward zero
    assign prod     = $signed({1'b0, r_gain}) * d;
    assign prod_adj = prod[PROD_W-1] ? prod + PROD_W'(255) : prod;
    assign scaled   = prod_adj[PROD_W-1:FRAC_W];

    // sum and saturation to the stored word
    assign centered = $signed({2'b00, r_s1.sample}) - $signed({2'b00, ZERO_LEVEL});
    assign sum      = SUM_W'(scaled) + SUM_W'(centered);
    always_comb begin
        if (sum > SUM_W'(WORD_MAX)) begin
            y = WORD_MAX;
        end else if (sum < SUM_W'(WORD_MIN)) begin
            y = WORD_MIN;
        end else begin
            y = sum[WORD_W-1:0];
        end
    end

    // dac byte
    assign y_out = {y[WORD_W-1], y} + $signed({{(WORD_W+1-SAMPLE_W){1'b0}}, ZERO_LEVEL});
    always_comb begin
        if (y_out < 0) begin
            echo_byte = '0;
        end else if (y_out > DAC_MAX) begin
            echo_byte = '1;
        end else begin
            echo_byte = y_out[SAMPLE_W-1:0];
        end
        n_dac = r_s1.fx ? echo_byte : r_s1.sample;
    end

    assign mem_we = s1_go && r_s1.fx;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain          <= GAIN_RESET;
            r_delay         <= DELAY_RESET;
            r_wp            <= '0;
            r_effect_on     <= 1'b0;
            r_button_before <= 1'b0;
            r_mvld          <= '0;
            r_s1_vld        <= 1'b0;
            r_fwd_vld       <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FEEDBACK_GAIN: r_gain  <= i_cfg_data;
                    CFG_DELAY_LENGTH:  r_delay <= i_cfg_data;
                endcase
            end
            if (acc) begin
                if (r_effect_on) begin
                    r_wp <= n_wp;
                end
                if (i_in.button && !r_button_before) begin
                    r_effect_on <= !r_effect_on;
                end
                r_button_before <= i_in.button;
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (mem_we) begin
                r_mvld[r_s1.waddr] <= 1'b1;
                r_fwd_vld <= 1'b1;
            end
            if (s1_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.sample <= i_in.sample;
            r_s1.fx     <= r_effect_on;
            r_s1.waddr  <= r_wp;
            r_s1_raddr  <= rd_addr;
            r_s1_mvld   <= r_mvld[rd_addr];
        end
        if (mem_we) begin
            r_fwd_addr <= r_s1.waddr;
            r_fwd_data <= y;
        end
        if (s1_go) begin
            r_out_dac <= n_dac;
            r_out_led <= r_s1.fx;
        end
    end

    // checks
    `FEB_ASSERT_NEXT(a_wp_hold, i_clk, i_rst_n, acc && !r_effect_on, $stable(r_wp))
    `FEB_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !i_in.ready, r_s1_vld && r_out_vld)
    `FEB_ASSERT_NEXT(a_fwd_track, i_clk, i_rst_n, mem_we, r_fwd_vld && (r_fwd_addr == $past(r_s1.waddr)))
    `FEB_ASSERT_NEXT(a_toggle, i_clk, i_rst_n, acc && i_in.button && !r_button_before, r_effect_on != $past(r_effect_on))

endmodule

`default_nettype wire
